FILE: sv/ple_pkg.sv
`default_nettype none

package ple_pkg;

    // default sizing of the store
    localparam int CAPACITY_DEF   = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // fixed field widths of the request and result words
    localparam int OP_W     = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [OP_W-1:0] OP_APPEND  = 3'd0;
    localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
    localparam logic [OP_W-1:0] OP_REPLACE = 3'd2;
    localparam logic [OP_W-1:0] OP_REMOVE  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ    = 3'd4;
    localparam logic [OP_W-1:0] OP_FIND    = 3'd5;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [POS_W-1:0]   position;
        logic [VALUE_W-1:0] value;
    } req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [POS_W-1:0]    index;
        logic [VALUE_W-1:0]  old_value;
        logic [POS_W-1:0]    count;
    } rsp_t;

endpackage

`default_nettype wire

FILE: sv/ple_ram.sv
`default_nettype none

module ple_ram #(
    parameter int DEPTH = ple_pkg::CAPACITY_DEF,
    parameter int WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write one word
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // register the read word
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

FILE: sv/positional_list_engine_unit.sv
`default_nettype none

// Channel   | Ports                 | Handshake
// ----------+-----------------------+-------------------------------------------
// request   | start, busy, req      | word taken at edge with start && !busy
// result    | done, rsp             | word valid for one cycle while done is high
//
// Bad position, full store and unused codes: result in the cycle after accept.
// Read and replace fetch the entry at position. Insert shifts the entries
// from position on one place up (nothing moves for append); remove shifts
// the later entries one place down; find scans from the front to a match.
// The entry memory has one read and one write port: one shift or one
// compare per cycle under the sequencer. Reset clears the count and control
// state; entries are never cleared. The receiver cannot stall; busy holds
// off new requests.

module positional_list_engine_unit #(
    parameter int CAPACITY   = ple_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = ple_pkg::DATA_WIDTH_DEF
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    output logic              busy,
    input  wire ple_pkg::req_t req,
    output logic              done,
    output ple_pkg::rsp_t     rsp
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > ple_pkg::POS_W) ? CW : ple_pkg::POS_W;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_SHIFT_UP = 3'd1;
    localparam logic [2:0] S_FETCH    = 3'd2;
    localparam logic [2:0] S_GRAB     = 3'd3;
    localparam logic [2:0] S_SHIFT_DN = 3'd4;
    localparam logic [2:0] S_FIND     = 3'd5;

    logic [2:0]                state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic [CW-1:0]             ptr_reg, ptr_next;
    logic                      pend_reg, pend_next;
    logic [AW-1:0]             wa_reg, wa_next;
    logic [CW-1:0]             pos_reg, pos_next;
    logic [ple_pkg::OP_W-1:0]  op_reg, op_next;
    logic [DATA_WIDTH-1:0]     word_reg, word_next;
    logic [DATA_WIDTH-1:0]     old_reg, old_next;
    logic                      done_reg, done_next;
    ple_pkg::rsp_t             rsp_reg, rsp_next;

    logic                      mem_we;
    logic [AW-1:0]             mem_waddr;
    logic [DATA_WIDTH-1:0]     mem_wdata;
    logic [AW-1:0]             mem_raddr;
    logic [DATA_WIDTH-1:0]     mem_rdata;

    logic [CW-1:0]             ptr_step;
    logic                      word_hit;
    logic [PW-1:0]             pos_ext;
    logic [PW-1:0]             cnt_ext;

    ple_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // shared pointer step and word compare
    assign ptr_step = (state_reg == S_SHIFT_UP) ? (ptr_reg - 1'b1) : (ptr_reg + 1'b1);
    assign word_hit = (mem_rdata == word_reg);
    assign pos_ext  = PW'(req.position);
    assign cnt_ext  = PW'(count_reg);

    // sequence one request
    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        ptr_next   = ptr_reg;
        pend_next  = pend_reg;
        wa_next    = wa_reg;
        pos_next   = pos_reg;
        op_next    = op_reg;
        word_next  = word_reg;
        old_next   = old_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        mem_we     = 1'b0;
        mem_waddr  = wa_reg;
        mem_wdata  = mem_rdata;
        mem_raddr  = ptr_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = req.op;
                    word_next = DATA_WIDTH'(req.value);
                    pos_next  = pos_ext[CW-1:0];
                    ptr_next  = '0;
                    pend_next = 1'b0;
                    rsp_next  = '0;
                    if (req.op == ple_pkg::OP_APPEND || req.op == ple_pkg::OP_INSERT)
                    begin
                        if (req.op == ple_pkg::OP_INSERT && pos_ext > cnt_ext)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ple_pkg::ST_BADPOS;
                        end
                        else if (count_reg == CW'(CAPACITY))
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ple_pkg::ST_FULL;
                        end
                        else
                        begin
                            if (req.op == ple_pkg::OP_APPEND)
                            begin
                                pos_next = count_reg;
                            end
                            ptr_next   = count_reg;
                            state_next = S_SHIFT_UP;
                        end
                    end
                    else if (req.op == ple_pkg::OP_REPLACE || req.op == ple_pkg::OP_REMOVE ||
                             req.op == ple_pkg::OP_READ)
                    begin
                        if (pos_ext >= cnt_ext)
                        begin
                            done_next       = 1'b1;
                            rsp_next.status = ple_pkg::ST_BADPOS;
                        end
                        else
                        begin
                            state_next = S_FETCH;
                        end
                    end
                    else if (req.op == ple_pkg::OP_FIND)
                    begin
                        state_next = S_FIND;
                    end
                    else
                    begin
                        done_next       = 1'b1;
                        rsp_next.status = ple_pkg::ST_OK;
                    end
                end
            end

            S_SHIFT_UP:
            begin
                // drain the word read last cycle one place up
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wa_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_reg > pos_reg)
                begin
                    mem_raddr = ptr_step[AW-1:0];
                    pend_next = 1'b1;
                    wa_next   = ptr_reg[AW-1:0];
                    ptr_next  = ptr_step;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = pos_reg[AW-1:0];
                    mem_wdata       = word_reg;
                    count_next      = count_reg + 1'b1;
                    done_next       = 1'b1;
                    rsp_next.status = ple_pkg::ST_OK;
                    rsp_next.index  = ple_pkg::POS_W'(pos_reg);
                    state_next      = S_IDLE;
                end
            end

            S_FETCH:
            begin
                mem_raddr  = pos_reg[AW-1:0];
                state_next = S_GRAB;
            end

            S_GRAB:
            begin
                old_next = mem_rdata;
                ptr_next = pos_reg;
                if (op_reg == ple_pkg::OP_REMOVE)
                begin
                    state_next = S_SHIFT_DN;
                end
                else
                begin
                    if (op_reg == ple_pkg::OP_REPLACE)
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = pos_reg[AW-1:0];
                        mem_wdata = word_reg;
                    end
                    done_next          = 1'b1;
                    rsp_next.status    = ple_pkg::ST_OK;
                    rsp_next.old_value = ple_pkg::VALUE_W'(mem_rdata);
                    state_next         = S_IDLE;
                end
            end

            S_SHIFT_DN:
            begin
                // drain the word read last cycle one place down
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = wa_reg;
                    mem_wdata = mem_rdata;
                end
                if (ptr_step < count_reg)
                begin
                    mem_raddr = ptr_step[AW-1:0];
                    pend_next = 1'b1;
                    wa_next   = ptr_reg[AW-1:0];
                    ptr_next  = ptr_step;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    count_next         = count_reg - 1'b1;
                    done_next          = 1'b1;
                    rsp_next.status    = ple_pkg::ST_OK;
                    rsp_next.old_value = ple_pkg::VALUE_W'(old_reg);
                    state_next         = S_IDLE;
                end
            end

            S_FIND:
            begin
                // compare the word read last cycle, then advance
                if (pend_reg && word_hit)
                begin
                    done_next       = 1'b1;
                    rsp_next.status = ple_pkg::ST_OK;
                    rsp_next.index  = ple_pkg::POS_W'(wa_reg);
                    state_next      = S_IDLE;
                end
                else if (ptr_reg < count_reg)
                begin
                    mem_raddr = ptr_reg[AW-1:0];
                    pend_next = 1'b1;
                    wa_next   = ptr_reg[AW-1:0];
                    ptr_next  = ptr_step;
                end
                else if (pend_reg)
                begin
                    pend_next = 1'b0;
                end
                else
                begin
                    done_next       = 1'b1;
                    rsp_next.status = ple_pkg::ST_NOTFOUND;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (done_next)
        begin
            rsp_next.count = ple_pkg::POS_W'(count_next);
        end
    end

    // hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            pend_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pend_reg  <= pend_next;
            done_reg  <= done_next;
        end
    end

    // hold the working payload
    always_ff @(posedge clk)
    begin
        ptr_reg  <= ptr_next;
        wa_reg   <= wa_next;
        pos_reg  <= pos_next;
        op_reg   <= op_next;
        word_reg <= word_next;
        old_reg  <= old_next;
        rsp_reg  <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_count_moves_with_result: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> done_reg)
        else $error("entry count changed without a result");

    a_full_only_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && rsp_reg.status == ple_pkg::ST_FULL |-> count_reg == CW'(CAPACITY))
        else $error("full status below capacity");

    a_up_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT_UP |-> ptr_reg <= count_reg && pos_reg <= ptr_reg)
        else $error("insert shift pointer out of range");

    a_dn_ptr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SHIFT_DN |-> ptr_reg < count_reg)
        else $error("remove shift pointer out of range");

endmodule

`default_nettype wire
